// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the feature window distance block.
// Depends on nothing; the macros compile to nothing when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define WFWD_ASSERT_IMP(name, ck, rn, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");
// next-cycle implication
`define WFWD_ASSERT_NXT(name, ck, rn, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");
`else
`define WFWD_ASSERT_IMP(name, ck, rn, ante, cons)
`define WFWD_ASSERT_NXT(name, ck, rn, ante, cons)
`endif

`endif

// File: rtl/wfwd_pkg.sv
// Shared types and constants of the feature window distance block.
// No dependencies; imported by the top level and its arithmetic units.
package wfwd_pkg;

	// register indexes on the configuration port
	typedef enum logic [2:0] {
		REG_PROP_MAX = 3'd0,
		REG_PROP_MIN = 3'd1,
		REG_PROG_MAX = 3'd2,
		REG_PROG_MIN = 3'd3,
		REG_MIX      = 3'd4,
		REG_NORM     = 3'd5,
		REG_COLUMNS  = 3'd6
	} wfwd_reg_t;

	localparam int CFG_AW    = 3;
	localparam int CFG_DW    = 16;

	// shared multiplier operand widths
	localparam int MUL_A_W   = 33;
	localparam int MUL_B_W   = 18;
	localparam int MUL_P_W   = MUL_A_W + MUL_B_W;

	// divide / root unit
	localparam int DS_OP_W   = 32;
	localparam int DS_DIV_W  = 16;
	localparam int DS_Q_W    = 24;
	localparam int DS_REM_W  = 20;
	localparam int DIV_STEPS  = 24;
	localparam int ROOT_STEPS = 16;

	typedef struct packed {
		logic                start;
		logic                is_root;
		logic [DS_OP_W-1:0]  operand;
		logic [DS_DIV_W-1:0] divisor;
	} wfwd_dsreq_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [DS_Q_W-1:0] result;
	} wfwd_dsstat_t;

endpackage

// File: rtl/wfwd_mul.sv
// Shared signed multiplier with a registered product.
// Depends on wfwd_pkg for operand widths.
module wfwd_mul
	import wfwd_pkg::*;
(
	input  logic                      clk,
	input  logic signed [MUL_A_W-1:0] a,
	input  logic signed [MUL_B_W-1:0] b,
	output logic signed [MUL_P_W-1:0] p
);

	logic signed [MUL_P_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= MUL_P_W'(a) * MUL_P_W'(b);
	end

	assign p = p_q;

endmodule

// File: rtl/wfwd_divsqrt.sv
// Iterative unsigned divider and integer square root sharing one
// compare/subtract step. Depends on wfwd_pkg for the request/status types.
module wfwd_divsqrt
	import wfwd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  wfwd_dsreq_t  req,
	output wfwd_dsstat_t stat
);

	logic                busy_q;
	logic                done_q;
	logic                root_q;
	logic [4:0]          cnt_q;
	logic [DS_OP_W-1:0]  x_q;
	logic [DS_REM_W-1:0] rem_q;
	logic [DS_Q_W-1:0]   q_q;
	logic [DS_DIV_W-1:0] div_q;

	logic [DS_REM_W-1:0] rem_sh;
	logic [DS_REM_W-1:0] trial;
	logic                ge;

	// root: bring down two bits, trial is 4*root+1; divide: one bit against divisor
	always_comb begin
		if (root_q) begin
			rem_sh = {rem_q[DS_REM_W-3:0], x_q[DS_OP_W-1 -: 2]};
			trial  = {2'b00, q_q[15:0], 2'b01};
		end else begin
			rem_sh = {rem_q[DS_REM_W-2:0], x_q[DS_OP_W-1]};
			trial  = {{(DS_REM_W-DS_DIV_W){1'b0}}, div_q};
		end
		ge = (rem_sh >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			root_q <= 1'b0;
			cnt_q  <= '0;
			x_q    <= '0;
			rem_q  <= '0;
			q_q    <= '0;
			div_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (!busy_q) begin
				if (req.start) begin
					busy_q <= 1'b1;
					root_q <= req.is_root;
					x_q    <= req.operand;
					div_q  <= req.divisor;
					rem_q  <= '0;
					q_q    <= '0;
					cnt_q  <= req.is_root ? 5'(ROOT_STEPS - 1) : 5'(DIV_STEPS - 1);
				end
			end else begin
				rem_q <= ge ? (rem_sh - trial) : rem_sh;
				q_q   <= {q_q[DS_Q_W-2:0], ge};
				x_q   <= root_q ? {x_q[DS_OP_W-3:0], 2'b00} : {x_q[DS_OP_W-2:0], 1'b0};
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 5'd1;
				end
			end
		end
	end

	assign stat.busy   = busy_q;
	assign stat.done   = done_q;
	assign stat.result = q_q;

endmodule

// File: rtl/weighted_feature_window_distance.sv
// Weighted feature window distance: sequencer, state and configuration.
// Depends on wfwd_pkg, wfwd_mul, wfwd_divsqrt and assert_macros.svh.
//
// Input items arrive on s_axis, one column pair per item, row by row; column 0
// carries energy and the row weight. A row closes on tlast (row end) or on
// tuser (window end); a window end also emits one result item on m_axis.
// Configuration is written through cfg_we/cfg_addr/cfg_wdata by the user while
// idle; the block does not enforce it. One item is in flight at a time;
// s_axis_tready is high only when idle. Per item, on the shared units:
//   column 0 item: two 24-step divisions for the scaling,
//   other counted column: square and saturating add,
//   ignored column: no square or add,
//   row end adds a 16-step root and six multiplies,
//   window end adds the final scaling by norm, then the result is registered on m_axis.
// The result item is held in an output register until taken; new items are
// accepted meanwhile, and a second window end waits only if the first is
// still not taken. Reset clears all state and restores default registers.
`include "assert_macros.svh"

module weighted_feature_window_distance
	import wfwd_pkg::*;
#(
	parameter int MAX_COLUMNS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [47:0]       s_axis_tdata,  // prop_value, prog_value, row_weight
	input  logic              s_axis_tlast,  // row_end
	input  logic              s_axis_tuser,  // window_end
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [63:0]       m_axis_tdata,  // energy_led_distance, spectrum_led_distance
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_addr,
	input  logic [CFG_DW-1:0] cfg_wdata
);

	localparam logic [6:0] MaxCols = 7'(MAX_COLUMNS);

	typedef enum logic [4:0] {
		S_IDLE, S_DIVA_GO, S_DIVA_WAIT, S_DIVB_GO, S_DIVB_WAIT, S_EDIST,
		S_SQ_MUL, S_SQ_ADD, S_ROW, S_SQRT_GO, S_SQRT_WAIT,
		S_T1A, S_T1B, S_T1C, S_T1D, S_T1E, S_T2B, S_T2C, S_T2D, S_T2E,
		S_FB, S_FC, S_EMIT
	} state_t;

	state_t state_q;

	// configuration
	logic signed [15:0] prop_max_q, prop_min_q, prog_max_q, prog_min_q;
	logic [8:0]         mix_q;
	logic signed [15:0] norm_q;
	logic [5:0]         cols_q;

	// item and row state
	logic signed [15:0] in_a_q, in_b_q;
	logic               rend_q, wend_q;
	logic [5:0]         col_q;
	logic [14:0]        row_energy_q;
	logic signed [15:0] held_w_q;
	logic [30:0]        row_sum_q;
	logic [63:0]        acc_e_q, acc_s_q;
	logic signed [24:0] qa_q, qb_q;
	logic [15:0]        root_q;
	logic signed [27:0] tmp_q, sum_q;
	logic [31:0]        fin_e_q, fin_s_q;
	logic               m_valid_q;
	logic [63:0]        m_data_q;

	logic accept;
	assign accept = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);

	logic [6:0] cnt_eff;
	assign cnt_eff = ({1'b0, cols_q} > MaxCols) ? MaxCols : {1'b0, cols_q};

	// shared divide / root unit
	wfwd_dsreq_t  ds_req;
	wfwd_dsstat_t ds_stat;
	logic         ds_waiting;

	assign ds_waiting = (state_q == S_DIVA_WAIT) || (state_q == S_DIVB_WAIT) ||
	                    (state_q == S_SQRT_WAIT);

	// energy scaling operands, reference side first then compared side
	logic               sel_b;
	logic signed [15:0] sc_v, sc_mx, sc_mn, rng, rng_nz;
	logic [16:0]        num17, nmag17;
	logic               nneg, dneg;
	logic [15:0]        dmag;
	logic signed [24:0] qsigned;

	always_comb begin
		sel_b  = (state_q == S_DIVB_GO) || (state_q == S_DIVB_WAIT);
		sc_v   = sel_b ? in_b_q : in_a_q;
		sc_mx  = sel_b ? prog_max_q : prop_max_q;
		sc_mn  = sel_b ? prog_min_q : prop_min_q;
		rng    = sc_mx - sc_mn;
		rng_nz = (rng == 16'sd0) ? 16'sd1 : rng;
		dneg   = rng_nz[15];
		dmag   = dneg ? 16'(-rng_nz) : rng_nz;
		num17  = {sc_v[15], sc_v} - {sc_mn[15], sc_mn};
		nneg   = num17[16];
		nmag17 = nneg ? 17'(-num17) : num17;
		qsigned = (nneg ^ dneg) ? -$signed({1'b0, ds_stat.result})
		                        :  $signed({1'b0, ds_stat.result});
	end

	always_comb begin
		ds_req.start   = (state_q == S_DIVA_GO) || (state_q == S_DIVB_GO) ||
		                 (state_q == S_SQRT_GO);
		ds_req.is_root = (state_q == S_SQRT_GO);
		ds_req.divisor = dmag;
		ds_req.operand = (state_q == S_SQRT_GO) ? {1'b0, row_sum_q}
		                                        : {nmag17[15:0], 16'h0000};
	end

	wfwd_divsqrt u_divsqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ds_req),
		.stat   (ds_stat)
	);

	// shared multiplier, operands picked by state
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] mul_p;
	logic signed [15:0]        diff;
	logic signed [15:0]        e_s;
	logic signed [9:0]         p_s, q_s;

	always_comb begin
		diff = in_a_q - in_b_q;
		e_s  = $signed({1'b0, row_energy_q});
		p_s  = $signed({1'b0, mix_q});
		q_s  = 10'sd256 - p_s;
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_SQ_MUL: begin
				mul_a = MUL_A_W'(diff);
				mul_b = MUL_B_W'(diff);
			end
			S_T1A: begin
				mul_a = MUL_A_W'(e_s);
				mul_b = MUL_B_W'(p_s);
			end
			S_T1B, S_T2B: begin
				mul_a = MUL_A_W'($signed({1'b0, root_q}));
				mul_b = (state_q == S_T1B) ? MUL_B_W'(q_s) : MUL_B_W'(p_s);
			end
			S_T1D, S_T2D: begin
				mul_a = MUL_A_W'(sum_q);
				mul_b = MUL_B_W'(held_w_q);
			end
			S_T1E: begin
				mul_a = MUL_A_W'(e_s);
				mul_b = MUL_B_W'(q_s);
			end
			S_T2E: begin
				mul_a = $signed(acc_e_q[48:16]);
				mul_b = MUL_B_W'(norm_q);
			end
			S_FB: begin
				mul_a = $signed(acc_s_q[48:16]);
				mul_b = MUL_B_W'(norm_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	wfwd_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	logic signed [25:0] ediff;
	logic [25:0]        emag;
	logic [31:0]        sq_sum;

	always_comb begin
		ediff  = 26'(qa_q) - 26'(qb_q);
		emag   = ediff[25] ? 26'(-ediff) : 26'(ediff);
		sq_sum = {1'b0, row_sum_q} + {1'b0, mul_p[30:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			prop_max_q   <= '0;
			prop_min_q   <= '0;
			prog_max_q   <= '0;
			prog_min_q   <= '0;
			mix_q        <= 9'd128;
			norm_q       <= 16'sd256;
			cols_q       <= 6'd13;
			in_a_q       <= '0;
			in_b_q       <= '0;
			rend_q       <= 1'b0;
			wend_q       <= 1'b0;
			col_q        <= '0;
			row_energy_q <= '0;
			held_w_q     <= '0;
			row_sum_q    <= '0;
			acc_e_q      <= '0;
			acc_s_q      <= '0;
			qa_q         <= '0;
			qb_q         <= '0;
			root_q       <= '0;
			tmp_q        <= '0;
			sum_q        <= '0;
			fin_e_q      <= '0;
			fin_s_q      <= '0;
			m_valid_q    <= 1'b0;
			m_data_q     <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_PROP_MAX: prop_max_q <= cfg_wdata;
					REG_PROP_MIN: prop_min_q <= cfg_wdata;
					REG_PROG_MAX: prog_max_q <= cfg_wdata;
					REG_PROG_MIN: prog_min_q <= cfg_wdata;
					REG_MIX:      mix_q      <= cfg_wdata[8:0];
					REG_NORM:     norm_q     <= cfg_wdata;
					REG_COLUMNS:  cols_q     <= cfg_wdata[5:0];
					default: ;
				endcase
			end

			// in S_EMIT the output register is reloaded below instead
			if (m_valid_q && m_axis_tready && (state_q != S_EMIT))
				m_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						in_a_q <= s_axis_tdata[15:0];
						in_b_q <= s_axis_tdata[31:16];
						rend_q <= s_axis_tlast;
						wend_q <= s_axis_tuser;
						if (col_q != 6'd63)
							col_q <= col_q + 6'd1;
						if (col_q == '0) begin
							held_w_q <= s_axis_tdata[47:32];
							state_q  <= S_DIVA_GO;
						end else if ({1'b0, col_q} < cnt_eff) begin
							state_q <= S_SQ_MUL;
						end else begin
							state_q <= S_ROW;
						end
					end
				end
				S_DIVA_GO: state_q <= S_DIVA_WAIT;
				S_DIVA_WAIT: begin
					if (ds_stat.done) begin
						qa_q    <= qsigned;
						state_q <= S_DIVB_GO;
					end
				end
				S_DIVB_GO: state_q <= S_DIVB_WAIT;
				S_DIVB_WAIT: begin
					if (ds_stat.done) begin
						qb_q    <= qsigned;
						state_q <= S_EDIST;
					end
				end
				S_EDIST: begin
					row_energy_q <= (emag > 26'd32767) ? 15'h7fff : emag[14:0];
					state_q      <= S_ROW;
				end
				S_SQ_MUL: state_q <= S_SQ_ADD;
				S_SQ_ADD: begin
					row_sum_q <= sq_sum[31] ? 31'h7fff_ffff : sq_sum[30:0];
					state_q   <= S_ROW;
				end
				S_ROW: state_q <= (rend_q || wend_q) ? S_SQRT_GO : S_IDLE;
				S_SQRT_GO: state_q <= S_SQRT_WAIT;
				S_SQRT_WAIT: begin
					if (ds_stat.done) begin
						root_q  <= ds_stat.result[15:0];
						state_q <= S_T1A;
					end
				end
				S_T1A: state_q <= S_T1B;
				S_T1B, S_T2B: begin
					tmp_q   <= mul_p[27:0];
					state_q <= (state_q == S_T1B) ? S_T1C : S_T2C;
				end
				S_T1C, S_T2C: begin
					sum_q   <= tmp_q + mul_p[27:0];
					state_q <= (state_q == S_T1C) ? S_T1D : S_T2D;
				end
				S_T1D: state_q <= S_T1E;
				S_T1E: begin
					acc_e_q <= acc_e_q + 64'(mul_p);
					state_q <= S_T2B;
				end
				S_T2D: state_q <= S_T2E;
				S_T2E: begin
					acc_s_q   <= acc_s_q + 64'(mul_p);
					col_q     <= '0;
					row_sum_q <= '0;
					state_q   <= wend_q ? S_FB : S_IDLE;
				end
				S_FB: begin
					fin_e_q <= mul_p[31:0];
					state_q <= S_FC;
				end
				S_FC: begin
					fin_s_q <= mul_p[31:0];
					acc_e_q <= '0;
					acc_s_q <= '0;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					// output register must be free or emptying this cycle
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q <= 1'b1;
						m_data_q  <= {fin_s_q, fin_e_q};
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	`WFWD_ASSERT_IMP(a_done_when_waiting, clk, arst_n, ds_stat.done, ds_waiting)
	`WFWD_ASSERT_IMP(a_no_accept_busy, clk, arst_n, ds_stat.busy, !s_axis_tready)
	`WFWD_ASSERT_NXT(a_col0_scales, clk, arst_n, accept && (col_q == '0), state_q == S_DIVA_GO)

endmodule
